@@ rtl/pcorr_pkg.sv @@
// ----------------------------------------------------------------------------
// pcorr_pkg
// Shared types and constants for the Pearson correlation block.
// ----------------------------------------------------------------------------
package pcorr_pkg;

  localparam int MAX_LEN   = 256;
  localparam int CNT_W     = 17;
  localparam int SUM_W     = 24;
  localparam int SQ_W      = 40;
  localparam int MUL_A_W   = 128;
  localparam int MUL_B_W   = 64;
  localparam int WIDE_W    = 64;
  localparam int RND_SHIFT = 30;
  localparam int MAG_W     = 15;
  localparam int MAG_TOP   = 14;
  localparam int BIT_W     = 4;
  localparam int KSQ_W     = 30;
  localparam int CORR_W    = 16;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_VAR = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  // running values handed from the accumulator to the solver
  typedef struct packed {
    logic [CNT_W-1:0]        n;
    logic signed [SUM_W-1:0] sx;
    logic signed [SUM_W-1:0] sy;
    logic [SQ_W-1:0]         sx2;
    logic [SQ_W-1:0]         sy2;
    logic signed [SQ_W-1:0]  sxy;
    logic                    ovf;
  } snap_t;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic [MUL_A_W-1:0] prod;
  } mul_rsp_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_START,
    BK_WAIT,
    BK_OUT
  } back_state_e;

  typedef enum logic [3:0] {
    OP_NSXY,
    OP_SXSY,
    OP_NSX2,
    OP_SXSX,
    OP_NSY2,
    OP_SYSY,
    OP_AA,
    OP_PB,
    OP_KK,
    OP_KP
  } op_e;

endpackage

@@ rtl/pcorr_front.sv @@
// ----------------------------------------------------------------------------
// pcorr_front
// Accepts pairs, updates the five running sums, pushes a snapshot on last.
// ----------------------------------------------------------------------------
module pcorr_front import pcorr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] x_value_i,
  input  logic signed [15:0] y_value_i,
  input  logic               last_pair_i,
  input  logic               q_full_i,
  output logic               push_o,
  output snap_t              snap_o
);

  logic [CNT_W-1:0]        n_q, n_d;
  logic signed [SUM_W-1:0] sx_q, sx_d, sy_q, sy_d;
  logic [SQ_W-1:0]         sx2_q, sx2_d, sy2_q, sy2_d;
  logic signed [SQ_W-1:0]  sxy_q, sxy_d;
  logic                    ovf_q, ovf_d;
  logic signed [31:0]      xx, yy, xy;
  logic                    accept, full;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign xx = x_value_i * x_value_i;
  assign yy = y_value_i * y_value_i;
  assign xy = x_value_i * y_value_i;
  assign full = (n_q >= CNT_W'(MAX_LEN));

  always_comb begin
    n_d = n_q; sx_d = sx_q; sy_d = sy_q;
    sx2_d = sx2_q; sy2_d = sy2_q; sxy_d = sxy_q; ovf_d = ovf_q;
    if (full) begin
      ovf_d = 1'b1;
    end else begin
      n_d   = n_q + CNT_W'(1);
      sx_d  = sx_q + {{(SUM_W-16){x_value_i[15]}}, x_value_i};
      sy_d  = sy_q + {{(SUM_W-16){y_value_i[15]}}, y_value_i};
      sx2_d = sx2_q + {{(SQ_W-32){1'b0}}, xx};
      sy2_d = sy2_q + {{(SQ_W-32){1'b0}}, yy};
      sxy_d = sxy_q + {{(SQ_W-32){xy[31]}}, xy};
    end
  end

  assign snap_o = '{n: n_d, sx: sx_d, sy: sy_d, sx2: sx2_d, sy2: sy2_d,
                    sxy: sxy_d, ovf: ovf_d};
  assign push_o = accept && last_pair_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= '0; sx_q <= '0; sy_q <= '0;
      sx2_q <= '0; sy2_q <= '0; sxy_q <= '0; ovf_q <= 1'b0;
    end else if (accept) begin
      if (last_pair_i) begin
        n_q <= '0; sx_q <= '0; sy_q <= '0;
        sx2_q <= '0; sy2_q <= '0; sxy_q <= '0; ovf_q <= 1'b0;
      end else begin
        n_q <= n_d; sx_q <= sx_d; sy_q <= sy_d;
        sx2_q <= sx2_d; sy2_q <= sy2_d; sxy_q <= sxy_d; ovf_q <= ovf_d;
      end
    end
  end

endmodule

@@ rtl/pcorr_queue.sv @@
// ----------------------------------------------------------------------------
// pcorr_queue
// Two-entry snapshot queue between accumulator and solver.
// ----------------------------------------------------------------------------
module pcorr_queue import pcorr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  snap_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output snap_t data_o
);

  snap_t      mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0; rd_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= !wr_q;
      if (do_pop) rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

endmodule

@@ rtl/pcorr_mul.sv @@
// ----------------------------------------------------------------------------
// pcorr_mul
// Shift-add multiplier, one multiplier bit per cycle, stops early on zero.
// ----------------------------------------------------------------------------
module pcorr_mul import pcorr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_req_t req_i,
  output mul_rsp_t rsp_o
);

  logic [MUL_A_W-1:0] acc_q, a_q;
  logic [MUL_B_W-1:0] b_q;
  logic               busy_q, done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
      end else if (busy_q && b_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= '0; a_q <= req_i.a; b_q <= req_i.b;
    end else if (busy_q && b_q != '0) begin
      if (b_q[0]) acc_q <= acc_q + a_q;
      a_q <= a_q << 1;
      b_q <= b_q >> 1;
    end
  end

  assign rsp_o = '{done: done_q, prod: acc_q};

endmodule

@@ rtl/pcorr_back.sv @@
// ----------------------------------------------------------------------------
// pcorr_back
// Solver: forms a, b1, b2 and searches the rounded magnitude bit by bit.
// ----------------------------------------------------------------------------
module pcorr_back import pcorr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  snap_t              q_data_i,
  output logic               pop_o,
  output mul_req_t           mul_req_o,
  input  mul_rsp_t           mul_rsp_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] correlation_o,
  output logic [1:0]         status_o
);

  back_state_e state_q, state_d;
  op_e         op_q, op_d;
  snap_t       s_q;
  logic signed [WIDE_W-1:0] t1_q, t1_d, a_q, a_d, b1_q, b1_d, b2_q, b2_d, b2_new;
  logic [MUL_A_W-1:0]  rhs_q, rhs_d, pp_q, pp_d;
  logic [KSQ_W-1:0]    kk_q, kk_d;
  logic [MAG_W-1:0]    m_q, m_d, m_t;
  logic [BIT_W-1:0]    bit_q, bit_d;
  logic [CORR_W-1:0]   k, corr_q, corr_d;
  status_e             st_q, st_d;
  logic [SQ_W-1:0]     sxy_mag;
  logic [SUM_W-1:0]    sx_mag, sy_mag;
  logic [WIDE_W-1:0]   amag, p64;
  logic                ok;
  logic                load;

  assign sxy_mag = s_q.sxy[SQ_W-1] ? SQ_W'(-s_q.sxy) : SQ_W'(s_q.sxy);
  assign sx_mag  = s_q.sx[SUM_W-1] ? SUM_W'(-s_q.sx) : SUM_W'(s_q.sx);
  assign sy_mag  = s_q.sy[SUM_W-1] ? SUM_W'(-s_q.sy) : SUM_W'(s_q.sy);
  assign amag    = a_q[WIDE_W-1] ? WIDE_W'(-a_q) : WIDE_W'(a_q);
  assign m_t     = m_q | (MAG_W'(1) << bit_q);
  assign k       = {1'b0, m_t} + {1'b0, m_t} - CORR_W'(1);
  assign p64     = mul_rsp_i.prod[WIDE_W-1:0];
  assign ok      = (mul_rsp_i.prod <= rhs_q);
  assign b2_new  = b2_q - $signed(p64);

  // operand select
  always_comb begin
    mul_req_o.start = (state_q == BK_START);
    mul_req_o.a = '0;
    mul_req_o.b = '0;
    case (op_q)
      OP_NSXY: begin mul_req_o.a = MUL_A_W'(s_q.n);  mul_req_o.b = MUL_B_W'(sxy_mag); end
      OP_SXSY: begin mul_req_o.a = MUL_A_W'(sx_mag); mul_req_o.b = MUL_B_W'(sy_mag);  end
      OP_NSX2: begin mul_req_o.a = MUL_A_W'(s_q.n);  mul_req_o.b = MUL_B_W'(s_q.sx2); end
      OP_SXSX: begin mul_req_o.a = MUL_A_W'(sx_mag); mul_req_o.b = MUL_B_W'(sx_mag);  end
      OP_NSY2: begin mul_req_o.a = MUL_A_W'(s_q.n);  mul_req_o.b = MUL_B_W'(s_q.sy2); end
      OP_SYSY: begin mul_req_o.a = MUL_A_W'(sy_mag); mul_req_o.b = MUL_B_W'(sy_mag);  end
      OP_AA:   begin mul_req_o.a = MUL_A_W'(amag);   mul_req_o.b = amag;              end
      OP_PB:   begin mul_req_o.a = MUL_A_W'(b1_q);   mul_req_o.b = b2_q;              end
      OP_KK:   begin mul_req_o.a = MUL_A_W'(k);      mul_req_o.b = MUL_B_W'(k);       end
      OP_KP:   begin mul_req_o.a = pp_q;             mul_req_o.b = MUL_B_W'(kk_q);    end
      default: begin mul_req_o.a = '0;               mul_req_o.b = '0;                end
    endcase
  end

  always_comb begin
    state_d = state_q; op_d = op_q;
    t1_d = t1_q; a_d = a_q; b1_d = b1_q; b2_d = b2_q;
    rhs_d = rhs_q; pp_d = pp_q; kk_d = kk_q; m_d = m_q; bit_d = bit_q;
    corr_d = corr_q; st_d = st_q;
    load = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          load = 1'b1;
          op_d = OP_NSXY;
          if (q_data_i.ovf) begin
            st_d = ST_OVERFLOW; corr_d = '0; state_d = BK_OUT;
          end else begin
            state_d = BK_START;
          end
        end
      end
      BK_START: state_d = BK_WAIT;
      BK_WAIT: begin
        if (mul_rsp_i.done) begin
          state_d = BK_START;
          case (op_q)
            OP_NSXY: begin
              t1_d = s_q.sxy[SQ_W-1] ? -$signed(p64) : $signed(p64);
              op_d = OP_SXSY;
            end
            OP_SXSY: begin
              a_d = (s_q.sx[SUM_W-1] ^ s_q.sy[SUM_W-1]) ? t1_q + $signed(p64)
                                                        : t1_q - $signed(p64);
              op_d = OP_NSX2;
            end
            OP_NSX2: begin b1_d = $signed(p64); op_d = OP_SXSX; end
            OP_SXSX: begin b1_d = b1_q - $signed(p64); op_d = OP_NSY2; end
            OP_NSY2: begin b2_d = $signed(p64); op_d = OP_SYSY; end
            OP_SYSY: begin
              b2_d = b2_new;
              op_d = OP_AA;
              if (b1_q <= 0 || b2_new <= 0) begin
                st_d = ST_ZERO_VAR; corr_d = '0; state_d = BK_OUT;
              end
            end
            OP_AA: begin rhs_d = mul_rsp_i.prod << RND_SHIFT; op_d = OP_PB; end
            OP_PB: begin
              pp_d = mul_rsp_i.prod; m_d = '0; bit_d = BIT_W'(MAG_TOP); op_d = OP_KK;
            end
            OP_KK: begin kk_d = mul_rsp_i.prod[KSQ_W-1:0]; op_d = OP_KP; end
            OP_KP: begin
              if (ok) m_d = m_t;
              if (bit_q == '0 || (ok && bit_q == BIT_W'(MAG_TOP))) begin
                corr_d = a_q[WIDE_W-1] ? -{1'b0, (ok ? m_t : m_q)}
                                       :  {1'b0, (ok ? m_t : m_q)};
                st_d = ST_OK;
                state_d = BK_OUT;
              end else begin
                bit_d = bit_q - BIT_W'(1);
                op_d = OP_KK;
              end
            end
            default: state_d = BK_IDLE;
          endcase
        end
      end
      BK_OUT: if (!out_stall_i) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  assign pop_o         = load;
  assign out_valid_o   = (state_q == BK_OUT);
  assign correlation_o = corr_q;
  assign status_o      = st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= BK_IDLE;
    else state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    if (load) s_q <= q_data_i;
    op_q <= op_d; t1_q <= t1_d; a_q <= a_d; b1_q <= b1_d; b2_q <= b2_d;
    rhs_q <= rhs_d; pp_q <= pp_d; kk_q <= kk_d; m_q <= m_d; bit_q <= bit_d;
    corr_q <= corr_d; st_q <= st_d;
  end

endmodule

@@ rtl/pearson_correlation.sv @@
// ----------------------------------------------------------------------------
// pearson_correlation
// Streaming Pearson coefficient of paired Q8.8 samples, result in Q1.14.
// ----------------------------------------------------------------------------
// Input channel: one pair per item (x_value_i, y_value_i, last_pair_i),
// taken when in_valid_i is high and in_stall_o is low. Pairs are taken one
// per cycle unless stalled; each pair up to MAX_LEN updates all five sums.
// Output channel: one item per vector (correlation_o, status_o), handed over
// when out_valid_o is high and out_stall_i is low. Status 0 ok, 1 zero
// variance, 2 more than MAX_LEN pairs; correlation is 0 unless status is 0.
// A last pair pushes the finished sums into a two-entry queue. The solver
// behind it works through them with one bit-serial shift-add multiplier:
// eight multiplies for a, b1, b2, a^2 and b1*b2, then two per result bit
// for up to 15 bits, each stopping early once its multiplier operand has no
// set bits left. An overflowed vector skips the multiplies, and a zero-variance
// one stops once b1 and b2 are known.
// in_stall_o rises only while the queue holds two vectors; a stalled result
// simply holds, the accumulator keeps taking pairs until the queue is full.
// Reset clears all sums, the queue and the solver; no result is pending.
// ----------------------------------------------------------------------------
module pearson_correlation import pcorr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] x_value_i,
  input  logic signed [15:0] y_value_i,
  input  logic               last_pair_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] correlation_o,
  output logic [1:0]         status_o
);

  snap_t    push_snap, pop_snap;
  logic     push, q_full, q_empty, pop;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  // accumulate pairs
  pcorr_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .x_value_i, .y_value_i, .last_pair_i,
    .q_full_i(q_full), .push_o(push), .snap_o(push_snap)
  );

  // decouple the accumulator from the solver
  pcorr_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(push_snap), .full_o(q_full),
    .pop_i(pop), .empty_o(q_empty), .data_o(pop_snap)
  );

  // shared wide multiplier
  pcorr_mul u_mul (
    .clk_i, .rst_ni, .req_i(mul_req), .rsp_o(mul_rsp)
  );

  // solver and result register
  pcorr_back u_back (
    .clk_i, .rst_ni, .q_empty_i(q_empty), .q_data_i(pop_snap), .pop_o(pop),
    .mul_req_o(mul_req), .mul_rsp_i(mul_rsp),
    .out_valid_o, .out_stall_i, .correlation_o, .status_o
  );

endmodule

@@ rtl/pcorr_checker.sv @@
// ----------------------------------------------------------------------------
// pcorr_checker
// Port-level checks on the result channel.
// ----------------------------------------------------------------------------
module pcorr_checker import pcorr_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [15:0] correlation_o,
  input logic [1:0]         status_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(correlation_o)
      && $stable(status_o))
    else $error("stalled result changed");

  a_zero_on_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> correlation_o == 16'sd0)
    else $error("nonzero correlation with error status");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 2'd3)
    else $error("undefined status");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_OK |->
      correlation_o <= 16'sd16384 && correlation_o >= -16'sd16384)
    else $error("correlation out of range");

endmodule

bind pearson_correlation pcorr_checker u_pcorr_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_stall_i, .correlation_o, .status_o
);
